/* hw/rtl/phb_pkg.sv */
// Shared types and constants for the provider health breaker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package phb_pkg;

    localparam int BACKOFF_MAX       = 5;
    localparam int BACKOFF_STEPS_DEF = 5;
    localparam int BACKOFF_IDX_W     = $clog2(BACKOFF_MAX);

    localparam int TIME_W = 48;
    localparam int CNT_W  = 32;
    localparam int SPAN_W = 32;
    localparam int CMD_W  = 3;
    localparam int CFG_IDX_W = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_SUCCESS  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TRANSIENT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HARD     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_EVALUATE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP1        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP2        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP3        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP4        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP5        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_DEFAULT = 3'd5;

    localparam logic [SPAN_W-1:0] STEP1_RST        = 32'd60000;
    localparam logic [SPAN_W-1:0] STEP2_RST        = 32'd120000;
    localparam logic [SPAN_W-1:0] STEP3_RST        = 32'd300000;
    localparam logic [SPAN_W-1:0] STEP4_RST        = 32'd900000;
    localparam logic [SPAN_W-1:0] STEP5_RST        = 32'd1800000;
    localparam logic [SPAN_W-1:0] HARD_DEFAULT_RST = 32'd86400000;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_COOLING  = 2'd1,
        ST_CAPACITY = 2'd2,
        ST_PAUSED   = 2'd3
    } t_status;

    typedef struct packed {
        logic [BACKOFF_MAX-1:0][SPAN_W-1:0] backoff;
        logic [SPAN_W-1:0]                  hard_default;
    } t_cfg;

    typedef struct packed {
        t_status           status;
        logic [TIME_W-1:0] open_until_ms;
        logic [CNT_W-1:0]  failure_run;
        logic [TIME_W-1:0] last_success_ms;
        logic [CNT_W-1:0]  hard_hit_count;
        logic              available;
    } t_result;

    // time + span, clamped at the top of the 48-bit range
    function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] t,
                                                   input logic [SPAN_W-1:0] span);
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + (TIME_W+1)'(span);
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/phb_cfg.sv */
// Configuration register file: backoff spans and hard capacity default span.
// Depends on phb_pkg.
`default_nettype none

module phb_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [phb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [phb_pkg::SPAN_W-1:0]      i_cfg_data,
    output phb_pkg::t_cfg                        o_cfg
);
    import phb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backoff[0]   <= STEP1_RST;
            r_cfg.backoff[1]   <= STEP2_RST;
            r_cfg.backoff[2]   <= STEP3_RST;
            r_cfg.backoff[3]   <= STEP4_RST;
            r_cfg.backoff[4]   <= STEP5_RST;
            r_cfg.hard_default <= HARD_DEFAULT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP1:        r_cfg.backoff[0]   <= i_cfg_data;
                CFG_STEP2:        r_cfg.backoff[1]   <= i_cfg_data;
                CFG_STEP3:        r_cfg.backoff[2]   <= i_cfg_data;
                CFG_STEP4:        r_cfg.backoff[3]   <= i_cfg_data;
                CFG_STEP5:        r_cfg.backoff[4]   <= i_cfg_data;
                CFG_HARD_DEFAULT: r_cfg.hard_default <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/phb_core.sv */
// Input register, breaker state and the single-pass update/evaluate logic.
// Depends on phb_pkg.
`default_nettype none

module phb_core #(
    parameter int BACKOFF_STEPS = phb_pkg::BACKOFF_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire phb_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [phb_pkg::CMD_W-1:0]     i_command,
    input  wire logic [phb_pkg::TIME_W-1:0]    i_time_ms,
    input  wire logic [phb_pkg::TIME_W-1:0]    i_cap_reset_ms,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output phb_pkg::t_result                   o_res
);
    import phb_pkg::*;

    // input register
    logic               r_in_vld;
    logic [CMD_W-1:0]   r_cmd;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_cap_reset;

    // breaker state
    logic [CNT_W-1:0]   r_fail_run,   n_fail_run;
    logic [TIME_W-1:0]  r_succ_time,  n_succ_time;
    logic [CNT_W-1:0]   r_hard_hits,  n_hard_hits;
    logic [TIME_W-1:0]  r_cool_dl,    n_cool_dl;
    logic [TIME_W-1:0]  r_hard_dl,    n_hard_dl;
    logic               r_pause,      n_pause;

    logic               adv;
    logic [CNT_W-1:0]   fail_inc;
    logic [BACKOFF_IDX_W-1:0] slot_idx;
    logic [TIME_W-1:0]  hard_cand;

    // an evaluate beat waits for room in the result register; others never stall
    assign adv        = r_in_vld && ((r_cmd != CMD_EVALUATE) || i_res_ready);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd       <= i_command;
            r_time      <= i_time_ms;
            r_cap_reset <= i_cap_reset_ms;
        end
    end

    assign fail_inc = inc_sat(r_fail_run);

    // run is at least one here; runs past the table use its last used entry
    always_comb begin
        if (fail_inc >= CNT_W'(BACKOFF_STEPS)) begin
            slot_idx = BACKOFF_IDX_W'(BACKOFF_STEPS - 1);
        end else begin
            slot_idx = fail_inc[BACKOFF_IDX_W-1:0] - BACKOFF_IDX_W'(1);
        end
    end

    assign hard_cand = (r_cap_reset != '0) ? r_cap_reset
                                           : add_sat(r_time, i_cfg.hard_default);

    always_comb begin
        n_fail_run  = r_fail_run;
        n_succ_time = r_succ_time;
        n_hard_hits = r_hard_hits;
        n_cool_dl   = r_cool_dl;
        n_hard_dl   = r_hard_dl;
        n_pause     = r_pause;
        case (r_cmd)
            CMD_SUCCESS: begin
                n_fail_run  = '0;
                n_succ_time = r_time;
                n_cool_dl   = '0;
            end
            CMD_TRANSIENT: begin
                n_fail_run = fail_inc;
                n_cool_dl  = add_sat(r_time, i_cfg.backoff[slot_idx]);
            end
            CMD_HARD: begin
                n_fail_run  = fail_inc;
                n_hard_hits = inc_sat(r_hard_hits);
                if (hard_cand > r_hard_dl) begin
                    n_hard_dl = hard_cand;
                end
            end
            CMD_PAUSE: begin
                n_pause = 1'b1;
            end
            CMD_RESUME: begin
                n_pause    = 1'b0;
                n_fail_run = '0;
                n_cool_dl  = '0;
                n_hard_dl  = '0;
            end
            CMD_CLEAR: begin
                n_fail_run  = '0;
                n_succ_time = '0;
                n_hard_hits = '0;
                n_cool_dl   = '0;
                n_hard_dl   = '0;
                n_pause     = 1'b0;
            end
            default: ;  // evaluate and unknown codes leave state alone
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_run  <= '0;
            r_succ_time <= '0;
            r_hard_hits <= '0;
            r_cool_dl   <= '0;
            r_hard_dl   <= '0;
            r_pause     <= 1'b0;
        end else if (adv) begin
            r_fail_run  <= n_fail_run;
            r_succ_time <= n_succ_time;
            r_hard_hits <= n_hard_hits;
            r_cool_dl   <= n_cool_dl;
            r_hard_dl   <= n_hard_dl;
            r_pause     <= n_pause;
        end
    end

    // evaluate: pause wins, then capacity, then cooling
    always_comb begin
        o_res.failure_run     = r_fail_run;
        o_res.last_success_ms = r_succ_time;
        o_res.hard_hit_count  = r_hard_hits;
        if (r_pause) begin
            o_res.status        = ST_PAUSED;
            o_res.open_until_ms = '0;
        end else if (r_hard_dl != '0 && r_time < r_hard_dl) begin
            o_res.status        = ST_CAPACITY;
            o_res.open_until_ms = r_hard_dl;
        end else if (r_cool_dl != '0 && r_time < r_cool_dl) begin
            o_res.status        = ST_COOLING;
            o_res.open_until_ms = r_cool_dl;
        end else begin
            o_res.status        = ST_READY;
            o_res.open_until_ms = '0;
        end
        o_res.available = (o_res.status == ST_READY);
    end

    assign o_res_valid = r_in_vld && (r_cmd == CMD_EVALUATE);

endmodule

`default_nettype wire

/* hw/rtl/phb_outreg.sv */
// Result register: holds one evaluate beat until the consumer takes it.
// Depends on phb_pkg.
`default_nettype none

module phb_outreg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_res_valid,
    output logic                  o_res_ready,
    input  wire phb_pkg::t_result i_res,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output phb_pkg::t_result      o_res
);
    import phb_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_res_ready = !r_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_res_ready) begin
            r_vld <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_vld;
    assign o_res       = r_res;

endmodule

`default_nettype wire

/* hw/rtl/provider_health_breaker_core.sv */
// Top level of the provider health breaker: config registers, core, result register.
// Depends on phb_pkg, phb_cfg, phb_core, phb_outreg.
//
//   port group  | direction | handshake                   | payload
//   ------------+-----------+-----------------------------+----------------------------------
//   config      | in        | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//   command     | in        | i_in_valid / o_in_ready     | i_command, i_time_ms, i_cap_reset_ms
//   result      | out       | o_out_valid / i_out_ready   | o_status .. o_available
//
// One command beat per cycle while the input side is not stalled. A command is held in the input
// register, where its state update closes in a single pass (one 49-bit saturating add and a 48-bit
// compare plus a span select); an evaluate result then goes from the input register into the
// result register, which drives the outputs.
// Only an evaluate held by a full, stalled result register stops the input side.
// Reset (synchronous, low) clears the breaker state and loads default spans; no clear pass.
`default_nettype none

module provider_health_breaker_core #(
    parameter int BACKOFF_STEPS = phb_pkg::BACKOFF_STEPS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [phb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [phb_pkg::SPAN_W-1:0]      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [phb_pkg::CMD_W-1:0]       i_command,
    input  wire logic [phb_pkg::TIME_W-1:0]      i_time_ms,
    input  wire logic [phb_pkg::TIME_W-1:0]      i_cap_reset_ms,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_status,
    output logic [phb_pkg::TIME_W-1:0]           o_open_until_ms,
    output logic [phb_pkg::CNT_W-1:0]            o_failure_run,
    output logic [phb_pkg::TIME_W-1:0]           o_last_success_ms,
    output logic [phb_pkg::CNT_W-1:0]            o_hard_hit_count,
    output logic                                 o_available
);
    import phb_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result out_res;
    logic    res_valid;
    logic    res_ready;

    phb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    phb_core #(
        .BACKOFF_STEPS (BACKOFF_STEPS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_time_ms      (i_time_ms),
        .i_cap_reset_ms (i_cap_reset_ms),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (core_res)
    );

    phb_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (core_res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_status          = out_res.status;
    assign o_open_until_ms   = out_res.open_until_ms;
    assign o_failure_run     = out_res.failure_run;
    assign o_last_success_ms = out_res.last_success_ms;
    assign o_hard_hit_count  = out_res.hard_hit_count;
    assign o_available       = out_res.available;

endmodule

`default_nettype wire

/* hw/rtl/phb_chk.sv */
// Port-level checker for the provider health breaker, bound to the top level.
// Depends on phb_pkg and provider_health_breaker_core.
`default_nettype none

module phb_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [1:0]                      o_status,
    input wire logic [phb_pkg::TIME_W-1:0]      o_open_until_ms,
    input wire logic                            o_available
);
    import phb_pkg::*;

    // a result beat stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before accept");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_available == (o_status == ST_READY)))
        else $error("available disagrees with status");

    a_until_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_READY || o_status == ST_PAUSED)
            |-> o_open_until_ms == '0)
        else $error("deadline reported for closed or paused circuit");

    a_until_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_COOLING || o_status == ST_CAPACITY)
            |-> o_open_until_ms != '0)
        else $error("open circuit without deadline");

endmodule

bind provider_health_breaker_core phb_chk u_phb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_open_until_ms (o_open_until_ms),
    .o_available     (o_available)
);

`default_nettype wire
